[design/floyd_steinberg_dither_unit_macros.svh]
// Assertion macros for the dither unit checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef FLOYD_STEINBERG_DITHER_UNIT_MACROS_SVH
`define FLOYD_STEINBERG_DITHER_UNIT_MACROS_SVH

// same-cycle implication
`define FSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// delayed implication
`define FSD_ASSERT_AFTER2(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

[design/fsd_pkg.sv]
// Shared types, constants and helpers for the Floyd-Steinberg dither unit.
// No dependencies.
package fsd_pkg;

	localparam int GREY_W     = 8;
	localparam int IMG_W_W    = 11;
	localparam int THR_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	// error values, sixteenths of an 8-bit step
	typedef logic signed [15:0] err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH,
		CFG_THRESHOLD
	} cfg_idx_t;

	localparam logic [IMG_W_W-1:0] IMG_W_RST   = 11'd1024;
	localparam logic [THR_W-1:0]   THR_RST     = 12'd2040;
	localparam logic [16:0]        WHITE_LEVEL = 17'd4080;
	localparam err_t               ERR_MAX     = 16'sh7FFF;
	localparam err_t               ERR_MIN     = -16'sh8000;

	// clamp a 17-bit two's complement sum to 16 bits
	function automatic err_t sat16(input logic [16:0] v);
		err_t r;
		if (v[16] != v[15]) begin
			r = v[16] ? ERR_MIN : ERR_MAX;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

[design/floyd_steinberg_dither_unit.sv]
// Floyd-Steinberg dither unit: one greyscale pixel in, one dithered bit out.
// An accepted word is registered into stage 1, then its bit is written into the output queue, raising out_valid.
// Throughput: one pixel per cycle while the output queue has room, set by the
// right-error feedback loop and the single write port of the error line memory.
// Reset: control state cleared, width 1024, threshold 2040; the line memory is
// not cleared, the first row of each frame reads zero error instead.
module floyd_steinberg_dither_unit
	import fsd_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [GREY_W-1:0]     grey,
	input  logic                  frame_start,
	// dithered output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  bit_res
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = (COL_W + 1 > IMG_W_W) ? COL_W + 1 : IMG_W_W;
	localparam logic [WID_W-1:0] MAX_W_V = WID_W'(MAX_WIDTH);
	// output queue: deep enough that stage 1 never stalls
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = OQ_PTR_W + 1;

	// ------------------------------------------------------------------
	// Configuration registers. Writes are expected only while the unit
	// is idle.
	// ------------------------------------------------------------------
	logic [IMG_W_W-1:0] image_width_q;
	logic [THR_W-1:0]   threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMG_W_RST;
			threshold_q   <= THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH: image_width_q <= cfg_data[IMG_W_W-1:0];
				CFG_THRESHOLD:   threshold_q   <= cfg_data[THR_W-1:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: column tracking and line memory read address.
	// Column bookkeeping depends only on the width, so it runs at accept
	// time and the read for the next pixel can go out back to back.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] column_q;
	logic             first_row_q;

	logic             accept;
	logic [WID_W-1:0] width_ext;
	logic [WID_W-1:0] w_eff;
	logic [COL_W-1:0] col_base;
	logic [WID_W-1:0] col_ext;
	logic [WID_W-1:0] col_clip;
	logic [COL_W-1:0] col0;
	logic             last0;
	logic             first0;

	assign accept    = in_valid && in_ready;
	assign width_ext = WID_W'(image_width_q);

	always_comb begin
		// zero acts as one, anything past the buffer as the buffer size
		if (width_ext == '0) begin
			w_eff = WID_W'(1);
		end else if (width_ext > MAX_W_V) begin
			w_eff = MAX_W_V;
		end else begin
			w_eff = width_ext;
		end
		col_base = frame_start ? '0 : column_q;
		col_ext  = WID_W'(col_base);
		// width shrunk mid-row: clip onto the last column
		col_clip = (col_ext >= w_eff) ? (w_eff - WID_W'(1)) : col_ext;
		col0     = col_clip[COL_W-1:0];
		last0    = (col_clip + WID_W'(1)) >= w_eff;
		first0   = frame_start || first_row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			column_q    <= last0 ? '0 : (col0 + COL_W'(1));
			first_row_q <= last0 ? 1'b0 : first0;
		end
	end

	// stage 1 registers
	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic              last_s1;
	logic              first_s1;
	logic              start_s1;
	logic [GREY_W-1:0] grey_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= col0;
			last_s1  <= last0;
			first_s1 <= first0;
			start_s1 <= frame_start;
			grey_s1  <= grey;
		end
	end

	// ------------------------------------------------------------------
	// Line memory. One write port shared by the below-left write of the
	// pixel in stage 1 and the deferred write that closes a row.
	// ------------------------------------------------------------------
	logic             mem_we;
	logic [COL_W-1:0] mem_waddr;
	err_t             mem_wdata;
	err_t             mem_rdata;

	logic             pend_valid_q;
	logic [COL_W-1:0] pend_addr_q;
	err_t             pend_data_q;

	logic             bl_we;
	err_t             bl_wdata;

	assign bl_we = valid_s1 && (col_s1 != '0);

	// The row-closing write goes out from the pend registers. The pixel in stage 1
	// while it goes out is at column zero and writes nothing, so the port
	// is always free for it.
	always_comb begin
		mem_we    = pend_valid_q || bl_we;
		mem_waddr = pend_valid_q ? pend_addr_q : (col_s1 - COL_W'(1));
		mem_wdata = pend_valid_q ? pend_data_q : bl_wdata;
	end

	fsd_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col0),
		.rd_data (mem_rdata),
		.we      (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: add error, quantize, diffuse.
	// ------------------------------------------------------------------
	err_t              right_error_q;
	err_t              below_left_acc_q;
	err_t              below_acc_q;

	err_t              line_val;
	err_t              e_in;
	logic [16:0]       sum_a;
	err_t              a16;
	err_t              re;
	err_t              bl;
	err_t              bb;
	err_t              v;
	err_t              thr_s;
	logic              bit1;
	logic signed [16:0] err;
	logic signed [19:0] e20;
	logic signed [19:0] err7;
	logic signed [19:0] err3;
	logic signed [19:0] err5;
	logic signed [19:0] err7_sh;
	logic signed [19:0] err3_sh;
	logic signed [19:0] err5_sh;
	logic signed [16:0] err1_sh;
	err_t              bl_new;

	always_comb begin
		// the row-closing word not yet in memory is the newest copy
		line_val = (pend_valid_q && (pend_addr_q == col_s1)) ? pend_data_q : mem_rdata;
		e_in     = first_s1 ? '0 : line_val;
		re       = start_s1 ? '0 : right_error_q;
		bl       = start_s1 ? '0 : below_left_acc_q;
		bb       = start_s1 ? '0 : below_acc_q;

		sum_a = {5'b0, grey_s1, 4'b0} + {e_in[15], e_in};
		a16   = sat16(sum_a);
		v     = sat16({a16[15], a16} + {re[15], re});

		thr_s = $signed({4'b0, threshold_q});
		bit1  = !(v < thr_s);
		err   = $signed({v[15], v} - (bit1 ? WHITE_LEVEL : 17'd0));

		// x7, x3, x5 by shift and add, then floor divide by 16
		e20     = {{3{err[16]}}, err};
		err7    = (e20 <<< 3) - e20;
		err3    = (e20 <<< 1) + e20;
		err5    = (e20 <<< 2) + e20;
		err7_sh = err7 >>> 4;
		err3_sh = err3 >>> 4;
		err5_sh = err5 >>> 4;
		err1_sh = err >>> 4;

		bl_wdata = sat16({bl[15], bl} + {err3_sh[15], err3_sh[15:0]});
		bl_new   = sat16({bb[15], bb} + {err5_sh[15], err5_sh[15:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_error_q    <= '0;
			below_left_acc_q <= '0;
			below_acc_q      <= '0;
			pend_valid_q     <= 1'b0;
		end else begin
			pend_valid_q <= valid_s1 && last_s1;
			if (valid_s1) begin
				right_error_q    <= last_s1 ? '0 : err7_sh[15:0];
				below_left_acc_q <= last_s1 ? '0 : bl_new;
				below_acc_q      <= last_s1 ? '0 : err1_sh[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pend_addr_q <= col_s1;
			pend_data_q <= bl_new;
		end
	end

	// ------------------------------------------------------------------
	// Output queue. Input is held off once the queue plus stage 1 could
	// overflow, so stage 1 always moves on.
	// ------------------------------------------------------------------
	logic                oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_ptr_q;
	logic [OQ_PTR_W-1:0] oq_rd_ptr_q;
	logic [OQ_CNT_W-1:0] oq_cnt_q;
	logic                oq_pop;

	assign out_valid = (oq_cnt_q != '0);
	assign bit_res   = oq_q[oq_rd_ptr_q];
	assign oq_pop    = out_valid && out_ready;
	assign in_ready  = (oq_cnt_q + OQ_CNT_W'(valid_s1)) < OQ_CNT_W'(OQ_DEPTH);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[oq_wr_ptr_q] <= bit1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_ptr_q <= '0;
			oq_rd_ptr_q <= '0;
			oq_cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				oq_wr_ptr_q <= oq_wr_ptr_q + OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_ptr_q <= oq_rd_ptr_q + OQ_PTR_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(valid_s1) - OQ_CNT_W'(oq_pop);
		end
	end

endmodule

[design/fsd_line_mem.sv]
// Error line buffer: one write port, one registered read port.
// A read that meets a write to the same entry on the same edge returns the new word.
// Depends on fsd_pkg.
module fsd_line_mem
	import fsd_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output err_t              rd_data,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  err_t              wr_data
);

	err_t mem_q [DEPTH];
	err_t rd_mem_q;
	err_t byp_data_q;
	logic byp_hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q   <= mem_q[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else if (rd_en) begin
			byp_hit_q <= we && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_hit_q ? byp_data_q : rd_mem_q;

endmodule

[design/fsd_checker.sv]
// Port-level checks for the dither unit, bound to the top level.
// Depends on floyd_steinberg_dither_unit_macros.svh.
`include "floyd_steinberg_dither_unit_macros.svh"

module fsd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic bit_res
);

	// words accepted but not yet delivered
	logic [2:0] outstanding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 3'(in_valid && in_ready)
				- 3'(out_valid && out_ready);
		end
	end

	`FSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bit_res), "stalled output word changed")
	`FSD_ASSERT_NOW(a_no_extra, out_valid, outstanding_q != 3'd0, "output word without a pixel")
	`FSD_ASSERT_NOW(a_idle_ready, outstanding_q == 3'd0, in_ready, "idle unit refuses input")
	`FSD_ASSERT_AFTER2(a_latency, in_valid && in_ready && outstanding_q == 3'd0, out_valid, "result late")

endmodule

bind floyd_steinberg_dither_unit fsd_checker u_fsd_checker (.*);

[tb/floyd_steinberg_dither_unit_tb.sv]
// Self-checking testbench for floyd_steinberg_dither_unit: pixel streams with
// random gaps and output stalls, checked word by word against a local model.
// Depends on fsd_pkg and the dither unit RTL only.
`timescale 1ns / 1ps

module floyd_steinberg_dither_unit_tb;
	import fsd_pkg::*;

	localparam int MAX_W = 1024;

	typedef struct packed {
		logic [GREY_W-1:0] grey;
		logic              frame_start;
	} pixel_t;

	// clock, reset, and every block input known from time zero
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic [GREY_W-1:0]     grey        = '0;
	logic                  frame_start = 1'b0;
	logic                  out_ready   = 1'b0;
	logic                  cfg_ready;
	logic                  in_ready;
	logic                  out_valid;
	logic                  bit_res;

	floyd_steinberg_dither_unit #(.MAX_WIDTH(MAX_W)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.grey       (grey),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bit_res    (bit_res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Error-diffusion model: own copy of registers and diffusion state.
	// ------------------------------------------------------------------
	logic [IMG_W_W-1:0] width_reg = IMG_W_RST;
	logic [THR_W-1:0]   thr_reg   = THR_RST;
	err_t               err_row [MAX_W];  // error line for the next row
	err_t               carry_right;      // 7/16 share for the next pixel
	err_t               acc_left;         // pending below-left sum
	err_t               acc_mid;          // pending below sum
	int                 col_pos;
	logic               top_row;
	// set when the width grows: the next word must open a new frame, so
	// line entries never written are never read
	logic               force_start = 1'b0;

	pixel_t pixel_fifo [$];     // words waiting for the driver
	logic   pending_bits [$];   // dithered bits still to come out
	logic   pix_taken = 1'b0;   // input word accepted at the last rising edge
	logic   steady    = 1'b0;   // no idling on either side while set
	int     gap_left  = 0;
	int     hold_left = 0;
	int     n_queued  = 0;
	int     n_checked = 0;
	int     n_bad     = 0;
	int     n_phases  = 0;

	function automatic int width_eff(input logic [IMG_W_W-1:0] wr);
		if (wr == 0) return 1;
		if (wr > MAX_W) return MAX_W;
		return int'(wr);
	endfunction

	function automatic int clip_err(input int x);
		if (x > 32767) return 32767;
		if (x < -32768) return -32768;
		return x;
	endfunction

	// quantise one pixel and spread its error; returns the dithered bit
	function automatic logic diffuse_pixel(input logic [GREY_W-1:0] g, input logic fs);
		int   w, c, e_in, v, e;
		logic row_end, q;
		w = width_eff(width_reg);
		if (fs) begin
			col_pos     = 0;
			top_row     = 1'b1;
			carry_right = '0;
			acc_left    = '0;
			acc_mid     = '0;
		end
		c = col_pos;
		// width shrunk mid-row: clamp to the last column
		if (c >= w) c = w - 1;
		row_end = (c + 1 >= w);
		e_in = top_row ? 0 : int'(err_row[c]);
		v = clip_err(clip_err(int'(g) * 16 + e_in) + int'(carry_right));
		q = (v >= int'(thr_reg));
		e = v - (q ? int'(WHITE_LEVEL) : 0);
		// >>> on int floors, as the shares are defined
		carry_right = row_end ? err_t'(0) : err_t'(clip_err((e * 7) >>> 4));
		if (c > 0) err_row[c-1] = err_t'(clip_err(int'(acc_left) + ((e * 3) >>> 4)));
		acc_left = err_t'(clip_err(int'(acc_mid) + ((e * 5) >>> 4)));
		acc_mid  = row_end ? err_t'(0) : err_t'(e >>> 4);
		if (row_end) begin
			err_row[c]  = acc_left;
			acc_left    = '0;
			acc_mid     = '0;
			carry_right = '0;
			col_pos     = 0;
			top_row     = 1'b0;
		end else begin
			col_pos = c + 1;
		end
		return q;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [GREY_W-1:0] pick_grey(input int style, input int base, input int k);
		int g;
		case (style)
			0: g = $urandom_range(0, 255);
			1: g = base;
			2: g = (base + k * 3) & 255;
			3: g = $urandom_range(0, 1) ? 255 : 0;
			default: begin
				g = base + $urandom_range(0, 12) - 6;
				if (g < 0) g = 0;
				if (g > 255) g = 255;
			end
		endcase
		return g[GREY_W-1:0];
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return CFG_DATA_W'($urandom_range(1, 8));
		if (r < 80) return CFG_DATA_W'($urandom_range(9, 40));
		if (r < 88) return CFG_DATA_W'($urandom_range(41, 100));
		if (r < 92) return 12'd0;
		if (r < 96) return CFG_DATA_W'($urandom_range(MAX_W + 1, 2047));
		return CFG_DATA_W'($urandom_range(101, MAX_W));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_threshold();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return CFG_DATA_W'($urandom_range(1600, 2500));
		if (r < 75) return CFG_DATA_W'($urandom_range(0, 4095));
		case ($urandom_range(0, 4))
			0: return 12'd0;
			1: return 12'd1;
			2: return 12'd4079;
			3: return 12'd4080;
			default: return 12'd4095;
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t word %0d: %s", $realtime, n_checked, msg);
		n_bad++;
	endtask

	task automatic queue_pixel(input logic [GREY_W-1:0] g, input logic fs);
		pixel_t p;
		p.grey        = g;
		p.frame_start = fs | force_start;
		force_start   = 1'b0;
		pending_bits.push_back(diffuse_pixel(p.grey, p.frame_start));
		pixel_fifo.push_back(p);
		n_queued++;
	endtask

	// sender holds off until every queued word has come back out; ends on a
	// falling edge so the next drive lines up with the driver
	task automatic settle_idle();
		while (pixel_fifo.size() != 0 || in_valid || pending_bits.size() != 0)
			@(negedge clk);
		// leave margin before the next phase
		repeat (4) @(negedge clk);
	endtask

	// register write, only issued while the block is idle; starts on its own
	// falling edge so back-to-back writes never drive cfg_valid twice at once
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		int old_w;
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH) begin
			old_w     = width_eff(width_reg);
			width_reg = val[IMG_W_W-1:0];
			if (width_eff(width_reg) > old_w) force_start = 1'b1;
		end else begin
			thr_reg = val[THR_W-1:0];
		end
	endtask

	// ------------------------------------------------------------------
	// Input driver: changes on the falling edge, holds a word until taken.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		pixel_t p;
		if (arst_n && (!in_valid || pix_taken)) begin
			if (gap_left > 0 && !steady) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pixel_fifo.size() != 0) begin
				p = pixel_fifo.pop_front();
				grey        <= p.grey;
				frame_start <= p.frame_start;
				in_valid    <= 1'b1;
				gap_left    <= steady ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output back-pressure: alternating ready and stall stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (steady) begin
				out_ready <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end else begin
				out_ready <= !out_ready;
				hold_left <= out_ready ? pick_gap() : $urandom_range(0, 10);
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: samples on the rising edge, checks against the oldest bit.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic exp_bit;
		pix_taken <= in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bits.size() == 0) begin
				flag_mismatch($sformatf("word with nothing pending, bit_res=%0b", bit_res));
			end else begin
				exp_bit = pending_bits.pop_front();
				if (bit_res !== exp_bit)
					flag_mismatch($sformatf("bit_res=%0b, want %0b", bit_res, exp_bit));
			end
			n_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus: directed corner cases, then random images.
	// ------------------------------------------------------------------
	initial begin
		int   n_rand, rows, npix, style, base;
		logic cont;
		logic big_done;
		n_rand   = 0;
		big_done = 1'b0;
		foreach (err_row[i]) err_row[i] = '0;
		carry_right = '0;
		acc_left    = '0;
		acc_mid     = '0;
		col_pos     = 0;
		top_row     = 1'b1;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset config (width 1024): start of a wide first row, grey extremes
		queue_pixel(8'd0, 1'b1);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd128, 1'b0);
		queue_pixel(8'd127, 1'b0);
		queue_pixel(8'd8, 1'b0);
		// shrink to 3 mid-row: next pixel is past the end, closes the row
		settle_idle();
		write_reg(CFG_IMAGE_WIDTH, 12'd3);
		queue_pixel(8'd200, 1'b0);
		queue_pixel(8'd10, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd0, 1'b0);
		// width 0 behaves as one pixel per row
		settle_idle();
		write_reg(CFG_IMAGE_WIDTH, 12'd0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd77, 1'b0);
		// threshold above white: full white can still give black
		settle_idle();
		write_reg(CFG_THRESHOLD, 12'd4095);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd255, 1'b0);
		// threshold zero: a black pixel with non-negative error still comes out white
		settle_idle();
		write_reg(CFG_THRESHOLD, 12'd0);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd0, 1'b0);
		// width above the maximum clamps to 1024; growth opens a frame
		settle_idle();
		write_reg(CFG_IMAGE_WIDTH, 12'd2047);
		write_reg(CFG_THRESHOLD, 12'd4080);
		queue_pixel(8'd255, 1'b1);
		queue_pixel(8'd0, 1'b0);
		queue_pixel(8'd255, 1'b0);
		queue_pixel(8'd1, 1'b0);
		// two short rows at the default threshold, the second reads the line
		settle_idle();
		write_reg(CFG_IMAGE_WIDTH, 12'd4);
		write_reg(CFG_THRESHOLD, THR_RST);
		queue_pixel(8'd254, 1'b1);
		queue_pixel(8'd1, 1'b0);
		queue_pixel(8'd128, 1'b0);
		queue_pixel(8'd129, 1'b0);
		queue_pixel(8'd64, 1'b0);
		queue_pixel(8'd192, 1'b0);
		queue_pixel(8'd100, 1'b0);
		queue_pixel(8'd170, 1'b0);

		// random images; one pass at the full 1024 width for the column wrap
		while (n_rand < 1950) begin
			n_phases++;
			style = $urandom_range(0, 4);
			base  = $urandom_range(0, 255);
			if (!big_done && n_rand >= 600) begin
				settle_idle();
				steady = 1'b0;
				write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(MAX_W, 2047)));
				write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(1600, 2500)));
				npix = MAX_W + $urandom_range(4, 24);
				for (int k = 0; k < npix; k++)
					queue_pixel(pick_grey(style, base, k), k == 0);
				big_done = 1'b1;
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					settle_idle();
					if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_WIDTH, pick_width());
					if ($urandom_range(0, 2) != 0) write_reg(CFG_THRESHOLD, pick_threshold());
				end
				steady = ($urandom_range(0, 4) == 0);
				// sometimes carry on the open frame instead of starting one
				cont = ($urandom_range(0, 7) == 0);
				rows = $urandom_range(1, 5);
				npix = rows * width_eff(width_reg);
				if (npix > 120) npix = $urandom_range(10, 120);
				// cut frames short now and then
				if ($urandom_range(0, 7) == 0) npix = $urandom_range(1, npix);
				for (int k = 0; k < npix; k++)
					queue_pixel(pick_grey(style, base, k),
						(k == 0 && !cont) || ($urandom_range(0, 99) == 0));
			end
			n_rand += npix;
		end

		settle_idle();
		repeat (8) @(negedge clk);
		if (pending_bits.size() != 0)
			flag_mismatch($sformatf("%0d words never came out", pending_bits.size()));
		$display("Ran %0d pixels over %0d random phases plus corner cases", n_queued, n_phases);
		$display("Checked %0d dithered words, %0d mismatches", n_checked, n_bad);
		if (n_bad == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Timed out with %0d words still pending", pending_bits.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
